// ===== hdl/errt_pkg.sv =====
// errt_pkg: types and constants of the echo reply rtt tracker
// used by echo_reply_rtt_tracker and errt_checker, no dependencies
package errt_pkg;

   typedef enum logic [2:0] {
      STATUS_ACCEPTED      = 3'd0,
      STATUS_FOREIGN       = 3'd1,
      STATUS_OTHER_SHOWN   = 3'd2,
      STATUS_OTHER_DROPPED = 3'd3,
      STATUS_SHORT         = 3'd4,
      STATUS_SHORT_REPLY   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_OWN_IDENT      = 2'd0,
      REG_EXPECTED_COUNT = 2'd1,
      REG_QUIET_MODE     = 2'd2,
      REG_VERBOSE_MODE   = 2'd3
   } reg_index_type;

   localparam int unsigned CSR_ADDR_WIDTH = 4;

   localparam logic [7:0]         TYPE_ECHO_REPLY = 8'd0;
   localparam logic signed [16:0] MIN_ICMP_LEN    = 17'sd8;
   localparam logic signed [16:0] MIN_REPLY_LEN   = 17'sd16;
   localparam logic signed [21:0] USEC_PER_SEC    = 22'sd1000000;
   localparam logic signed [20:0] USEC_MULT       = 21'sd1000000;

   localparam logic signed [31:0] RTT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] RTT_MIN = 32'sh8000_0000;
   localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

endpackage

// ===== hdl/echo_reply_rtt_tracker.sv =====
// echo_reply_rtt_tracker: classifies icmp packets, forms the rtt of echo replies
// and keeps min, max, total and count; depends on errt_pkg
//
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  header fields and timestamps
// rsp_      out        rsp_valid/rsp_stall  status, rtt and statistics
// csr       in/out     psel/penable/pready  four registers at 4*index
//
// one transfer per cycle in each direction while no stall holds the pipeline;
// the input register is followed by the stages classify, seconds times 1e6,
// rtt add and saturate, then the statistics update into the result register
// reset is synchronous and clears valids, statistics and registers
// each stage holds while the one after it is full and stalled
module echo_reply_rtt_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [3:0]                          req_header_words,
   input  logic [15:0]                         req_packet_length,
   input  logic [7:0]                          req_message_type,
   input  logic [7:0]                          req_message_code,
   input  logic [15:0]                         req_message_ident,
   input  logic [15:0]                         req_message_seq,
   input  logic [7:0]                          req_hop_ttl,
   input  logic [31:0]                         req_recv_seconds,
   input  logic [19:0]                         req_recv_micros,
   input  logic [31:0]                         req_sent_seconds,
   input  logic [19:0]                         req_sent_micros,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic signed [16:0]                  rsp_icmp_length,
   output logic signed [31:0]                  rsp_rtt_micros,
   output logic [15:0]                         rsp_reply_seq,
   output logic [7:0]                          rsp_reply_ttl,
   output logic [7:0]                          rsp_reply_type,
   output logic [7:0]                          rsp_reply_code,
   output logic signed [31:0]                  rsp_min_rtt,
   output logic signed [31:0]                  rsp_max_rtt,
   output logic signed [47:0]                  rsp_total_rtt,
   output logic [31:0]                         rsp_reply_count,
   output logic                                rsp_finished,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [errt_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import errt_pkg::*;

   // configuration registers
   logic [15:0]       own_ident_ff;
   logic [16:0]       expected_count_ff;
   logic              quiet_mode_ff;
   logic              verbose_mode_ff;
   logic              csr_write;
   reg_index_type     csr_index;

   // stage handshake
   logic              s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic              s0_ready, s1_ready, s2_ready, s3_ready, out_ready;

   // input register
   logic [3:0]        s0_header_words_ff;
   logic [15:0]       s0_packet_length_ff;
   logic [7:0]        s0_type_ff;
   logic [7:0]        s0_code_ff;
   logic [15:0]       s0_ident_ff;
   logic [15:0]       s0_seq_ff;
   logic [7:0]        s0_ttl_ff;
   logic [31:0]       s0_recv_seconds_ff;
   logic [19:0]       s0_recv_micros_ff;
   logic [31:0]       s0_sent_seconds_ff;
   logic [19:0]       s0_sent_micros_ff;

   // classify stage
   logic signed [16:0] ilen_in;
   status_type         status_in;
   logic               fin_in;
   logic signed [21:0] us_raw;
   logic               borrow;
   logic signed [21:0] us_in;
   logic signed [33:0] secs_in;

   status_type         s1_status_ff;
   logic signed [16:0] s1_ilen_ff;
   logic               s1_fin_ff;
   logic [15:0]        s1_seq_ff;
   logic [7:0]         s1_ttl_ff;
   logic [7:0]         s1_type_ff;
   logic [7:0]         s1_code_ff;
   logic signed [33:0] s1_secs_ff;
   logic signed [21:0] s1_us_ff;

   // multiply stage
   logic signed [53:0] prod_in;

   status_type         s2_status_ff;
   logic signed [16:0] s2_ilen_ff;
   logic               s2_fin_ff;
   logic [15:0]        s2_seq_ff;
   logic [7:0]         s2_ttl_ff;
   logic [7:0]         s2_type_ff;
   logic [7:0]         s2_code_ff;
   logic signed [53:0] s2_prod_ff;
   logic signed [21:0] s2_us_ff;

   // add and saturate stage
   logic signed [54:0] total_us;
   logic signed [31:0] rtt_in;

   status_type         s3_status_ff;
   logic signed [16:0] s3_ilen_ff;
   logic               s3_fin_ff;
   logic [15:0]        s3_seq_ff;
   logic [7:0]         s3_ttl_ff;
   logic [7:0]         s3_type_ff;
   logic [7:0]         s3_code_ff;
   logic signed [31:0] s3_rtt_ff;

   // statistics and result register
   logic signed [31:0] least_rtt_ff, least_rtt_in;
   logic signed [31:0] greatest_rtt_ff, greatest_rtt_in;
   logic signed [47:0] rtt_sum_ff, rtt_sum_in;
   logic [31:0]        accepted_count_ff, accepted_count_in;
   logic signed [48:0] sum_wide;
   logic               stats_update;

   status_type         out_status_ff;
   logic signed [16:0] out_ilen_ff;
   logic signed [31:0] out_rtt_ff;
   logic [15:0]        out_seq_ff;
   logic [7:0]         out_ttl_ff;
   logic [7:0]         out_type_ff;
   logic [7:0]         out_code_ff;
   logic               out_fin_ff;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      case (csr_index)
         REG_OWN_IDENT:      prdata = {16'd0, own_ident_ff};
         REG_EXPECTED_COUNT: prdata = {15'd0, expected_count_ff};
         REG_QUIET_MODE:     prdata = {31'd0, quiet_mode_ff};
         REG_VERBOSE_MODE:   prdata = {31'd0, verbose_mode_ff};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ident_ff      <= 16'd0;
         expected_count_ff <= 17'd0;
         quiet_mode_ff     <= 1'b0;
         verbose_mode_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_OWN_IDENT:      own_ident_ff      <= pwdata[15:0];
            REG_EXPECTED_COUNT: expected_count_ff <= pwdata[16:0];
            REG_QUIET_MODE:     quiet_mode_ff     <= pwdata[0];
            REG_VERBOSE_MODE:   verbose_mode_ff   <= pwdata[0];
            default: ;
         endcase
      end
   end

   // ready chain from the result register back to the input
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req_stall = !s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s0_ready)  s0_valid_ff  <= req_valid;
         if (s1_ready)  s1_valid_ff  <= s0_valid_ff;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (out_ready) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s0_header_words_ff  <= req_header_words;
         s0_packet_length_ff <= req_packet_length;
         s0_type_ff          <= req_message_type;
         s0_code_ff          <= req_message_code;
         s0_ident_ff         <= req_message_ident;
         s0_seq_ff           <= req_message_seq;
         s0_ttl_ff           <= req_hop_ttl;
         s0_recv_seconds_ff  <= req_recv_seconds;
         s0_recv_micros_ff   <= req_recv_micros;
         s0_sent_seconds_ff  <= req_sent_seconds;
         s0_sent_micros_ff   <= req_sent_micros;
      end
   end

   // classify and split the timestamp difference
   always_comb begin
      ilen_in = $signed({1'b0, s0_packet_length_ff})
              - $signed({11'd0, s0_header_words_ff, 2'b00});
      if (ilen_in < MIN_ICMP_LEN) begin
         status_in = STATUS_SHORT;
      end else if (s0_type_ff == TYPE_ECHO_REPLY) begin
         if (s0_ident_ff != own_ident_ff) begin
            status_in = STATUS_FOREIGN;
         end else if (ilen_in < MIN_REPLY_LEN) begin
            status_in = STATUS_SHORT_REPLY;
         end else begin
            status_in = STATUS_ACCEPTED;
         end
      end else begin
         status_in = verbose_mode_ff ? STATUS_OTHER_SHOWN : STATUS_OTHER_DROPPED;
      end
      fin_in = (status_in == STATUS_ACCEPTED) && !quiet_mode_ff
            && (expected_count_ff != 17'd0)
            && ({1'b0, s0_seq_ff} == expected_count_ff - 17'd1);

      us_raw  = $signed({2'b00, s0_recv_micros_ff}) - $signed({2'b00, s0_sent_micros_ff});
      borrow  = us_raw[21];
      us_in   = borrow ? us_raw + USEC_PER_SEC : us_raw;
      secs_in = $signed({2'b00, s0_recv_seconds_ff}) - $signed({2'b00, s0_sent_seconds_ff})
              - $signed({33'd0, borrow});
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_status_ff <= status_in;
         s1_ilen_ff   <= ilen_in;
         s1_fin_ff    <= fin_in;
         s1_seq_ff    <= s0_seq_ff;
         s1_ttl_ff    <= s0_ttl_ff;
         s1_type_ff   <= s0_type_ff;
         s1_code_ff   <= s0_code_ff;
         s1_secs_ff   <= secs_in;
         s1_us_ff     <= us_in;
      end
   end

   // seconds to microseconds
   assign prod_in = 54'(s1_secs_ff) * 54'(USEC_MULT);

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_status_ff <= s1_status_ff;
         s2_ilen_ff   <= s1_ilen_ff;
         s2_fin_ff    <= s1_fin_ff;
         s2_seq_ff    <= s1_seq_ff;
         s2_ttl_ff    <= s1_ttl_ff;
         s2_type_ff   <= s1_type_ff;
         s2_code_ff   <= s1_code_ff;
         s2_prod_ff   <= prod_in;
         s2_us_ff     <= s1_us_ff;
      end
   end

   // add the microsecond part and saturate to 32 bits
   always_comb begin
      total_us = 55'(s2_prod_ff) + 55'(s2_us_ff);
      if (s2_status_ff != STATUS_ACCEPTED) begin
         rtt_in = 32'sd0;
      end else if (total_us[54:31] != {24{total_us[54]}}) begin
         rtt_in = total_us[54] ? RTT_MIN : RTT_MAX;
      end else begin
         rtt_in = total_us[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_status_ff <= s2_status_ff;
         s3_ilen_ff   <= s2_ilen_ff;
         s3_fin_ff    <= s2_fin_ff;
         s3_seq_ff    <= s2_seq_ff;
         s3_ttl_ff    <= s2_ttl_ff;
         s3_type_ff   <= s2_type_ff;
         s3_code_ff   <= s2_code_ff;
         s3_rtt_ff    <= rtt_in;
      end
   end

   // statistics update, in step with the result register
   assign stats_update = out_ready && s3_valid_ff && (s3_status_ff == STATUS_ACCEPTED);

   always_comb begin
      least_rtt_in    = (s3_rtt_ff < least_rtt_ff) ? s3_rtt_ff : least_rtt_ff;
      greatest_rtt_in = (s3_rtt_ff > greatest_rtt_ff) ? s3_rtt_ff : greatest_rtt_ff;
      sum_wide        = $signed({rtt_sum_ff[47], rtt_sum_ff})
                      + $signed({{17{s3_rtt_ff[31]}}, s3_rtt_ff});
      if (sum_wide[48] != sum_wide[47]) begin
         rtt_sum_in = sum_wide[48] ? SUM_MIN : SUM_MAX;
      end else begin
         rtt_sum_in = sum_wide[47:0];
      end
      accepted_count_in = (accepted_count_ff == '1) ? accepted_count_ff
                                                    : accepted_count_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         least_rtt_ff      <= RTT_MAX;
         greatest_rtt_ff   <= RTT_MIN;
         rtt_sum_ff        <= 48'sd0;
         accepted_count_ff <= 32'd0;
      end else if (stats_update) begin
         least_rtt_ff      <= least_rtt_in;
         greatest_rtt_ff   <= greatest_rtt_in;
         rtt_sum_ff        <= rtt_sum_in;
         accepted_count_ff <= accepted_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_status_ff <= s3_status_ff;
         out_ilen_ff   <= s3_ilen_ff;
         out_rtt_ff    <= s3_rtt_ff;
         out_seq_ff    <= s3_seq_ff;
         out_ttl_ff    <= s3_ttl_ff;
         out_type_ff   <= s3_type_ff;
         out_code_ff   <= s3_code_ff;
         out_fin_ff    <= s3_fin_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_icmp_length = out_ilen_ff;
   assign rsp_rtt_micros  = out_rtt_ff;
   assign rsp_reply_seq   = out_seq_ff;
   assign rsp_reply_ttl   = out_ttl_ff;
   assign rsp_reply_type  = out_type_ff;
   assign rsp_reply_code  = out_code_ff;
   assign rsp_min_rtt     = least_rtt_ff;
   assign rsp_max_rtt     = greatest_rtt_ff;
   assign rsp_total_rtt   = rtt_sum_ff;
   assign rsp_reply_count = accepted_count_ff;
   assign rsp_finished    = out_fin_ff;

endmodule

// ===== hdl/errt_checker.sv =====
// errt_checker: port-level assertions for echo_reply_rtt_tracker
// depends on errt_pkg; bound to the top level at the end of this file
module errt_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [2:0]                          rsp_status,
   input  logic signed [31:0]                  rsp_rtt_micros,
   input  logic signed [31:0]                  rsp_min_rtt,
   input  logic signed [31:0]                  rsp_max_rtt,
   input  logic [31:0]                         rsp_reply_count,
   input  logic                                rsp_finished
);
   import errt_pkg::*;

   // a stalled result transfer holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_rtt_micros) && $stable(rsp_reply_count))
      else $error("stalled result changed");

   // only accepted replies carry an rtt or finish
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_ACCEPTED) |-> rsp_rtt_micros == 32'sd0 && !rsp_finished)
      else $error("rtt or finish on a packet that was not accepted");

   // an accepted reply is counted and the extremes are ordered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ACCEPTED)
         |-> rsp_reply_count != 32'd0 && rsp_min_rtt <= rsp_max_rtt
            && rsp_min_rtt <= rsp_rtt_micros && rsp_rtt_micros <= rsp_max_rtt)
      else $error("statistics inconsistent with accepted reply");

   // the count moves by at most one between results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall ##1 rsp_valid
         |-> rsp_reply_count == $past(rsp_reply_count, 1)
            || rsp_reply_count == $past(rsp_reply_count, 1) + 32'd1)
      else $error("reply count jumped");

endmodule

bind echo_reply_rtt_tracker errt_checker u_errt_checker (.*);
